FILE: rtl/core/rwip_pkg.sv
package rwip_pkg;

    localparam int ADDR_IN_W = 32;
    localparam int WORD_W    = 30;
    localparam int DATA_W    = 32;
    localparam int OFF_W     = 6;
    localparam int CNT_W     = 2;
    localparam int NUM_W     = 12;
    localparam int DONE_W    = 13;
    localparam int LIMIT_W   = 13;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 2;

    // operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // register map
    localparam logic [PADDR_W-1:0] REG_ITEM_LIMIT = 2'd0;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
    localparam logic [OFF_W-1:0]   OFFSET_SPAN = 6'h3F;
    localparam logic [DONE_W-1:0]  DONE_MAX    = 13'h1FFF;
    localparam logic [CNT_W-1:0]   EXTRA_FULL  = 2'd2;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] word;
        logic [DATA_W-1:0] value;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic              item_open;
        logic [CNT_W-1:0]  extra_count;
        logic [DONE_W-1:0] items_done;
    } back_status_t;

endpackage

FILE: rtl/core/rwip_ifs.sv
interface rwip_in_if
    import rwip_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [ADDR_IN_W-1:0] byte_address;
    logic [DATA_W-1:0]    write_value;

    modport source (output valid, operation, byte_address, write_value, input ready);
    modport sink   (input valid, operation, byte_address, write_value, output ready);
endinterface

interface rwip_out_if
    import rwip_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] base_word_address;
    logic [DATA_W-1:0] base_data;
    logic [OFF_W-1:0]  second_offset;
    logic [DATA_W-1:0] second_data;
    logic [OFF_W-1:0]  third_offset;
    logic [DATA_W-1:0] third_data;
    logic [CNT_W-1:0]  extra_count;
    logic [NUM_W-1:0]  item_number;
    logic              last_item;
    logic              overflow;

    modport source (
        output valid, base_word_address, base_data, second_offset, second_data,
               third_offset, third_data, extra_count, item_number, last_item, overflow,
        input  ready
    );
    modport sink (
        input  valid, base_word_address, base_data, second_offset, second_data,
               third_offset, third_data, extra_count, item_number, last_item, overflow,
        output ready
    );
endinterface

FILE: rtl/core/register_write_item_packer.sv
//  channel     | dir | beat
//  ------------+-----+----------------------------------------------------------
//  writes      | in  | operation, byte_address, write_value (write or finish)
//  items       | out | packed command item: base, two extra writes, count, flags
//  apb         | in  | item_limit register at byte address 0, read back on prdata
//
//  one write beat per cycle sustained while the queue has room; a beat that
//  closes an item shows it after passing the two-entry queue and then the
//  output register, which the packer loads from the queue head when it pops
//  the beat; the single packer state update per cycle sets the rate
//  reset clears the queue, the open item flag, item count and overflow flag;
//  item_limit resets to 4096
//  a stalled items channel only holds back beats that would emit an item;
//  writes that join the open item keep draining the queue meanwhile
module register_write_item_packer
    import rwip_pkg::*;
#(
    parameter int MAX_ITEMS = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    rwip_in_if.sink            writes,
    rwip_out_if.source         items,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               cfg_wr;
    q_head_t            head;
    logic               pop;
    back_status_t       status;

    // apb register: written on the access phase, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_ITEM_LIMIT);

    always_comb
    begin
        limit_next = cfg_wr ? pwdata[LIMIT_W-1:0] : limit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign prdata = (paddr == REG_ITEM_LIMIT) ? APB_W'(limit_reg) : '0;

    // front: decode beats into the queue
    rwip_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .writes (writes),
        .head   (head),
        .pop    (pop)
    );

    // back: pack writes into items, emit through the output register
    rwip_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .item_limit (limit_reg),
        .status     (status),
        .items      (items)
    );

    // the extra slot count never passes two
    a_extra_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.extra_count != 2'd3)
        else $error("extra slot count out of range");

    // an item with no extra writes carries empty slots
    a_empty_slots: assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.extra_count == 2'd0 |->
            items.second_offset == '0 && items.third_offset == '0)
        else $error("unused slot not cleared");

    // one extra write uses the second slot only, at a nonzero offset
    a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.extra_count == 2'd1 |->
            items.second_offset != '0 && items.third_offset == '0)
        else $error("slot fill order broken");

    // a finish leaves the list count at zero
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.entry.op == OP_FINISH |=> status.items_done == '0 && !status.item_open)
        else $error("finish did not end the list");

endmodule

FILE: rtl/core/rwip_front.sv
module rwip_front
    import rwip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rwip_in_if.sink    writes,
    output q_head_t    head,
    input  logic       pop
);

    q_entry_t            mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    q_entry_t            entry;

    // decode the beat into a queue entry
    always_comb
    begin
        entry.op    = writes.operation;
        entry.word  = writes.byte_address[ADDR_IN_W-1:2];
        entry.value = writes.write_value;
    end

    assign writes.ready = (count_reg != QCNT_W'(QDEPTH));
    assign push         = writes.valid && writes.ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

endmodule

FILE: rtl/core/rwip_back.sv
module rwip_back
    import rwip_pkg::*;
#(
    parameter int MAX_ITEMS = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  q_head_t            head,
    output logic               pop,
    input  logic [LIMIT_W-1:0] item_limit,
    output back_status_t       status,
    rwip_out_if.source         items
);

    localparam int LIM_W = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W = (LIM_W > DONE_W) ? LIM_W : DONE_W;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_ITEMS);

    // open item
    logic              open_reg, open_next;
    logic [WORD_W-1:0] base_reg, base_next;
    logic [DATA_W-1:0] base_data_reg, base_data_next;
    logic [OFF_W-1:0]  sec_off_reg, sec_off_next;
    logic [DATA_W-1:0] sec_data_reg, sec_data_next;
    logic [OFF_W-1:0]  thr_off_reg, thr_off_next;
    logic [DATA_W-1:0] thr_data_reg, thr_data_next;
    logic [CNT_W-1:0]  extra_reg, extra_next;
    logic [DONE_W-1:0] done_reg, done_next;
    logic              ovf_reg, ovf_next;

    // output register
    logic              oval_reg, oval_next;
    logic              emit_last;
    logic              ovf_now;

    logic              is_finish;
    logic [WORD_W-1:0] diff;
    logic              fits;
    logic              emit;
    logic              out_free;
    logic [CMP_W-1:0]  lim_ext;
    logic [CMP_W-1:0]  eff_limit;

    assign is_finish = (head.entry.op == OP_FINISH);
    assign diff      = head.entry.word - base_reg;
    assign fits      = open_reg && (head.entry.word > base_reg)
                       && (diff < WORD_W'(OFFSET_SPAN)) && (extra_reg != EXTRA_FULL);
    assign emit      = open_reg && (is_finish || !fits);
    assign out_free  = !oval_reg || items.ready;
    assign pop       = head.valid && (!emit || out_free);
    assign emit_last = is_finish;

    assign lim_ext   = CMP_W'(item_limit);
    assign eff_limit = (lim_ext > MAX_C) ? MAX_C : lim_ext;
    assign ovf_now   = ovf_reg || (CMP_W'(done_reg) >= eff_limit);

    always_comb
    begin
        open_next      = open_reg;
        base_next      = base_reg;
        base_data_next = base_data_reg;
        sec_off_next   = sec_off_reg;
        sec_data_next  = sec_data_reg;
        thr_off_next   = thr_off_reg;
        thr_data_next  = thr_data_reg;
        extra_next     = extra_reg;
        done_next      = done_reg;
        ovf_next       = ovf_reg;
        oval_next      = oval_reg && !items.ready;

        if (pop)
        begin
            if (emit)
            begin
                oval_next = 1'b1;
                ovf_next  = ovf_now;
                if (done_reg != DONE_MAX)
                begin
                    done_next = done_reg + 1'b1;
                end
            end
            priority if (is_finish)
            begin
                open_next = 1'b0;
                done_next = '0;
                ovf_next  = 1'b0;
            end
            else if (fits)
            begin
                extra_next = extra_reg + 1'b1;
                if (extra_reg == '0)
                begin
                    sec_off_next  = diff[OFF_W-1:0];
                    sec_data_next = head.entry.value;
                end
                else
                begin
                    thr_off_next  = diff[OFF_W-1:0];
                    thr_data_next = head.entry.value;
                end
            end
            else
            begin
                // start a fresh item with this write as its base
                open_next      = 1'b1;
                base_next      = head.entry.word;
                base_data_next = head.entry.value;
                sec_off_next   = '0;
                sec_data_next  = '0;
                thr_off_next   = '0;
                thr_data_next  = '0;
                extra_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            extra_reg <= '0;
            done_reg  <= '0;
            ovf_reg   <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            open_reg  <= open_next;
            extra_reg <= extra_next;
            done_reg  <= done_next;
            ovf_reg   <= ovf_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        base_data_reg <= base_data_next;
        sec_off_reg   <= sec_off_next;
        sec_data_reg  <= sec_data_next;
        thr_off_reg   <= thr_off_next;
        thr_data_reg  <= thr_data_next;
        if (pop && emit)
        begin
            items.base_word_address <= base_reg;
            items.base_data         <= base_data_reg;
            items.second_offset     <= sec_off_reg;
            items.second_data       <= sec_data_reg;
            items.third_offset      <= thr_off_reg;
            items.third_data        <= thr_data_reg;
            items.extra_count       <= extra_reg;
            items.item_number       <= done_reg[NUM_W-1:0];
            items.last_item         <= emit_last;
            items.overflow          <= ovf_now;
        end
    end

    assign items.valid        = oval_reg;
    assign status.item_open   = open_reg;
    assign status.extra_count = extra_reg;
    assign status.items_done  = done_reg;

endmodule
